@@ hdl/ympc_pkg.sv @@
// ----------------------------------------------------------------------------
// ympc_pkg
// Shared widths, codes and types of the YMODEM receive packet control.
// ----------------------------------------------------------------------------
package ympc_pkg;

  // field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned KEEP_W   = 11;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned ERR_W    = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;

  // defaults of the top level parameters
  localparam int unsigned MAX_PAYLOAD_DEF     = 1024;
  localparam int unsigned SIZE_DIGITS_MAX_DEF = 127;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 1'b1;
  localparam logic [SIZE_W-1:0]    MAX_FILE_SIZE_RST = 31'd1048576;
  localparam logic [ERR_W-1:0]     ERROR_LIMIT_RST   = 8'd5;

  // link opcodes
  localparam logic [OP_W-1:0] OP_BYTE        = 3'd0;
  localparam logic [OP_W-1:0] OP_PKT_END     = 3'd1;
  localparam logic [OP_W-1:0] OP_EOF         = 3'd2;
  localparam logic [OP_W-1:0] OP_SND_CANCEL  = 3'd3;
  localparam logic [OP_W-1:0] OP_RX_ERR      = 3'd4;
  localparam logic [OP_W-1:0] OP_LINK_ABORT  = 3'd5;
  localparam logic [OP_W-1:0] OP_TIMEOUT     = 3'd6;
  localparam logic [OP_W-1:0] OP_WRITE_FAIL  = 3'd7;

  // character codes used by the size parser
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  typedef enum logic [CODE_W-1:0] {
    R_ACK  = 3'd0,
    R_NAK  = 3'd1,
    R_CA   = 3'd2,
    R_ACKC = 3'd3,
    R_C    = 3'd4
  } reply_e;

  typedef enum logic [CODE_W-1:0] {
    S_OK     = 3'd0,
    S_ABORT  = 3'd1,
    S_MAXERR = 3'd2,
    S_OVER   = 3'd3,
    S_NULL   = 3'd4,
    S_WERR   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CMD_BYTE,
    CMD_PKT_END,
    CMD_EOF,
    CMD_SND_CANCEL,
    CMD_RX_ERR,
    CMD_LINK_ABORT,
    CMD_TIMEOUT,
    CMD_WRITE_FAIL
  } cmd_e;

  // classified item as queued between front and back
  typedef struct packed {
    cmd_e       kind;
    logic       is_nul;
    logic       is_digit;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] max_file_size;
    logic [ERR_W-1:0]  error_limit;
  } cfg_t;

endpackage

@@ hdl/ympc_channels.sv @@
// ----------------------------------------------------------------------------
// ympc channels
// Valid/ready channels of the receive packet control: input items, results
// and configuration writes.
// ----------------------------------------------------------------------------
interface ympc_in_if
  import ympc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface ympc_out_if
  import ympc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] reply_code;
  logic [CODE_W-1:0] status;
  logic [KEEP_W-1:0] keep_length;
  logic [SIZE_W-1:0] declared_len;
  logic              xfer_done;

  modport source (output valid, output reply_code, output status, output keep_length,
                  output declared_len, output xfer_done, input ready);
  modport sink   (input valid, input reply_code, input status, input keep_length,
                  input declared_len, input xfer_done, output ready);
endinterface

interface ympc_cfg_if
  import ympc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/ympc_front.sv @@
// ----------------------------------------------------------------------------
// ympc_front
// Accepts link items and classifies them for the back end queue.
// ----------------------------------------------------------------------------
module ympc_front
  import ympc_pkg::*;
(
  ympc_in_if.sink in_i,
  input  logic    full_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.is_nul   = (in_i.data_byte == CHAR_NUL);
    cmd_o.is_digit = (in_i.data_byte >= CHAR_ZERO) && (in_i.data_byte <= CHAR_NINE);
    cmd_o.digit    = 4'(in_i.data_byte - CHAR_ZERO);
    unique case (in_i.opcode)
      OP_BYTE:       cmd_o.kind = CMD_BYTE;
      OP_PKT_END:    cmd_o.kind = CMD_PKT_END;
      OP_EOF:        cmd_o.kind = CMD_EOF;
      OP_SND_CANCEL: cmd_o.kind = CMD_SND_CANCEL;
      OP_RX_ERR:     cmd_o.kind = CMD_RX_ERR;
      OP_LINK_ABORT: cmd_o.kind = CMD_LINK_ABORT;
      OP_TIMEOUT:    cmd_o.kind = CMD_TIMEOUT;
      OP_WRITE_FAIL: cmd_o.kind = CMD_WRITE_FAIL;
      default:       cmd_o.kind = CMD_BYTE;
    endcase
  end

endmodule

@@ hdl/ympc_queue.sv @@
// ----------------------------------------------------------------------------
// ympc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module ympc_queue
  import ympc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ hdl/ympc_back.sv @@
// ----------------------------------------------------------------------------
// ympc_back
// Executes queued items: header parse, truncation, retries and the
// registered result stage.
// ----------------------------------------------------------------------------
module ympc_back
  import ympc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD     = MAX_PAYLOAD_DEF,
  parameter int unsigned SIZE_DIGITS_MAX = SIZE_DIGITS_MAX_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            cmd_valid_i,
  input  cmd_t            cmd_i,
  output logic            pop_o,
  ympc_out_if.source      out_o
);

  localparam int unsigned PosW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned CharW = $clog2(SIZE_DIGITS_MAX + 1);
  localparam int unsigned ProdW = SIZE_W + 4;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_NAME,
    PH_SIZE,
    PH_DONE
  } phase_e;

  // file and error state
  logic [ERR_W-1:0]  err_cnt_q, err_cnt_d;
  logic              eof_seen_q, eof_seen_d;
  logic              hdr_taken_q, hdr_taken_d;
  logic [SIZE_W-1:0] decl_size_q, decl_size_d;
  logic [SIZE_W-1:0] room_q, room_d;       // declared size less bytes kept
  // packet state
  logic [PosW-1:0]   byte_pos_q, byte_pos_d;
  phase_e            phase_q, phase_d;
  logic [SIZE_W-1:0] acc_q, acc_d;
  logic              not_empty_q, not_empty_d;
  logic [CharW-1:0]  chars_q, chars_d;
  // result register
  logic              out_valid_q, out_valid_d;
  reply_e            reply_q, reply_d;
  status_e           status_q, status_d;
  logic [KEEP_W-1:0] keep_q, keep_d;
  logic [SIZE_W-1:0] fsize_q, fsize_d;
  logic              done_q, done_d;

  logic              is_byte;
  logic [ERR_W-1:0]  err_inc;
  logic              err_over;
  logic [KEEP_W-1:0] keep_sel;
  logic [ProdW-1:0]  prod;

  assign is_byte = (cmd_i.kind == CMD_BYTE);
  assign pop_o   = cmd_valid_i && (is_byte || !out_valid_q || out_o.ready);

  assign err_inc  = (err_cnt_q == {ERR_W{1'b1}}) ? err_cnt_q : err_cnt_q + 1'b1;
  assign err_over = (err_inc > cfg_i.error_limit);
  assign keep_sel = (room_q < SIZE_W'(byte_pos_q)) ? room_q[KEEP_W-1:0]
                                                   : KEEP_W'(byte_pos_q);
  // acc * 10 + digit, by shifts
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + ProdW'(cmd_i.digit);

  always_comb begin
    reply_e  rep;
    status_e st;
    logic [KEEP_W-1:0] kp;
    logic [SIZE_W-1:0] fs;
    logic              dn;

    rep = R_ACK;
    st  = S_OK;
    kp  = '0;
    fs  = decl_size_q;
    dn  = 1'b0;

    err_cnt_d   = err_cnt_q;
    eof_seen_d  = eof_seen_q;
    hdr_taken_d = hdr_taken_q;
    decl_size_d = decl_size_q;
    room_d      = room_q;
    byte_pos_d  = byte_pos_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    not_empty_d = not_empty_q;
    chars_d     = chars_q;
    out_valid_d = out_valid_q && !out_o.ready;
    reply_d     = reply_q;
    status_d    = status_q;
    keep_d      = keep_q;
    fsize_d     = fsize_q;
    done_d      = done_q;

    if (pop_o) begin
      if (is_byte) begin
        // bytes past the payload size are dropped
        if (byte_pos_q < PosW'(MAX_PAYLOAD)) begin
          byte_pos_d = byte_pos_q + 1'b1;
          if (!hdr_taken_q) begin
            unique case (phase_q)
              PH_FIRST: begin
                if (cmd_i.is_nul) begin
                  phase_d = PH_DONE;
                end else begin
                  not_empty_d = 1'b1;
                  phase_d     = PH_NAME;
                end
              end
              PH_NAME: begin
                if (cmd_i.is_nul) begin
                  phase_d = PH_SIZE;
                end
              end
              PH_SIZE: begin
                if (cmd_i.is_digit) begin
                  acc_d   = (prod[ProdW-1:SIZE_W] != '0) ? SIZE_SAT : prod[SIZE_W-1:0];
                  chars_d = chars_q + 1'b1;
                  if (chars_q == CharW'(SIZE_DIGITS_MAX - 1)) begin
                    phase_d = PH_DONE;
                  end
                end else begin
                  phase_d = PH_DONE;
                end
              end
              PH_DONE: begin
              end
              default: begin
              end
            endcase
          end
        end
      end else begin
        unique case (cmd_i.kind)
          CMD_PKT_END: begin
            if (!hdr_taken_q) begin
              if (!not_empty_q) begin
                err_cnt_d = err_inc;
                rep = err_over ? R_CA : R_NAK;
                st  = err_over ? S_MAXERR : S_OK;
              end else begin
                fs = acc_q;
                if (acc_q == '0) begin
                  rep = R_CA;
                  st  = S_NULL;
                end else if (acc_q > cfg_i.max_file_size) begin
                  rep = R_CA;
                  st  = S_OVER;
                end else begin
                  rep         = R_ACKC;
                  hdr_taken_d = 1'b1;
                  decl_size_d = acc_q;
                  room_d      = acc_q;
                end
              end
            end else begin
              kp     = keep_sel;
              room_d = room_q - SIZE_W'(keep_sel);
              rep    = R_ACK;
            end
          end
          CMD_EOF: begin
            if (!eof_seen_q) begin
              eof_seen_d = 1'b1;
              rep        = R_NAK;
            end else begin
              rep = R_ACK;
              dn  = 1'b1;
            end
          end
          CMD_SND_CANCEL: begin
            rep = R_ACK;
            st  = S_ABORT;
          end
          CMD_RX_ERR: begin
            err_cnt_d = err_inc;
            rep = err_over ? R_CA : R_NAK;
            st  = err_over ? S_MAXERR : S_OK;
          end
          CMD_LINK_ABORT: begin
            rep = R_CA;
            st  = S_ABORT;
          end
          CMD_TIMEOUT: begin
            err_cnt_d = err_inc;
            rep = err_over ? R_CA : R_C;
            st  = err_over ? S_MAXERR : S_OK;
          end
          CMD_WRITE_FAIL: begin
            rep = R_CA;
            st  = S_WERR;
          end
          default: begin
          end
        endcase

        // every event closes the packet
        byte_pos_d  = '0;
        phase_d     = PH_FIRST;
        acc_d       = '0;
        not_empty_d = 1'b0;
        chars_d     = '0;
        // session end
        if (dn || st != S_OK) begin
          eof_seen_d  = 1'b0;
          hdr_taken_d = 1'b0;
          decl_size_d = '0;
          room_d      = '0;
        end

        out_valid_d = 1'b1;
        reply_d     = rep;
        status_d    = st;
        keep_d      = kp;
        fsize_d     = fs;
        done_d      = dn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_cnt_q   <= '0;
      eof_seen_q  <= 1'b0;
      hdr_taken_q <= 1'b0;
      decl_size_q <= '0;
      room_q      <= '0;
      byte_pos_q  <= '0;
      phase_q     <= PH_FIRST;
      acc_q       <= '0;
      not_empty_q <= 1'b0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
      reply_q     <= R_ACK;
      status_q    <= S_OK;
      keep_q      <= '0;
      fsize_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      err_cnt_q   <= err_cnt_d;
      eof_seen_q  <= eof_seen_d;
      hdr_taken_q <= hdr_taken_d;
      decl_size_q <= decl_size_d;
      room_q      <= room_d;
      byte_pos_q  <= byte_pos_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      not_empty_q <= not_empty_d;
      chars_q     <= chars_d;
      out_valid_q <= out_valid_d;
      reply_q     <= reply_d;
      status_q    <= status_d;
      keep_q      <= keep_d;
      fsize_q     <= fsize_d;
      done_q      <= done_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.reply_code   = reply_q;
  assign out_o.status       = status_q;
  assign out_o.keep_length  = keep_q;
  assign out_o.declared_len = fsize_q;
  assign out_o.xfer_done    = done_q;

  a_room_in_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    room_q <= decl_size_q)
    else $error("remaining room exceeds declared size");

  a_no_hdr_no_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_taken_q |-> (decl_size_q == '0) && (room_q == '0))
    else $error("declared size held without a header");

  a_done_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> (reply_q == R_ACK) && (status_q == S_OK))
    else $error("session end without ACK and ok status");

  a_keep_only_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (keep_q != '0) |-> (reply_q == R_ACK) && (status_q == S_OK))
    else $error("kept bytes on a non-ACK result");

  a_event_clears_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !is_byte |=> (byte_pos_q == '0) && (phase_q == PH_FIRST))
    else $error("packet state not cleared after an event");

endmodule

@@ hdl/ymodem_receive_packet_control.sv @@
// ----------------------------------------------------------------------------
// ymodem_receive_packet_control
// YMODEM receiver packet control: header size parse, truncation, retries.
// ----------------------------------------------------------------------------
// Results: an accepted event item passes through the queue and then the
//   result register, from which its result is presented.
// Throughput: one item per cycle while the queue is not full; the back end
//   retires one queued item a cycle; an event item waits only while a
//   result is still held in the result register.
// Reset: asynchronous, active low; clears all file, packet and error state,
//   the queue and the result register; config returns to 1048576 and 5.
// ----------------------------------------------------------------------------
module ymodem_receive_packet_control
  import ympc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD     = MAX_PAYLOAD_DEF,     // 128..1024
  parameter int unsigned SIZE_DIGITS_MAX = SIZE_DIGITS_MAX_DEF  // 10..127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ympc_in_if.sink     in_i,
  ympc_cfg_if.sink    cfg_i,
  ympc_out_if.source  out_o
);

  // Configuration registers. Always ready; the user must write them only while idle, the block does not enforce it.
  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAX_FILE_SIZE: cfg_d.max_file_size = cfg_i.data[SIZE_W-1:0];
        CFG_ERROR_LIMIT:   cfg_d.error_limit   = cfg_i.data[ERR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_file_size <= MAX_FILE_SIZE_RST;
      cfg_q.error_limit   <= ERROR_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: decode opcode and byte class, push into the queue.
  logic push;
  logic full;
  cmd_t front_cmd;

  ympc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  // Queue: lets the link side keep streaming while a result is held.
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  ympc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Back: state update and registered result. Bytes retire without a
  // result, so they never wait on the output side.
  ympc_back #(
    .MAX_PAYLOAD     (MAX_PAYLOAD),
    .SIZE_DIGITS_MAX (SIZE_DIGITS_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
